// ----- hdl/periodic_event_timer_table_core_assert.svh -----
// Assertion macros shared by the checker of the periodic timer table.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef PERIODIC_EVENT_TIMER_TABLE_CORE_ASSERT_SVH
`define PERIODIC_EVENT_TIMER_TABLE_CORE_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define PETT_ASSERT_NOW(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("pett assertion failed");

// Consequence that must hold in the cycle after the antecedent.
`define PETT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pett assertion failed");

`endif

// ----- hdl/pett_pkg.sv -----
// Package for the periodic timer table: sizes, transfer structs, codes and helpers.
// Used by the core and by its checker; depends on nothing else.
package pett_pkg;

  localparam int SLOTS     = 16;
  localparam int KEY_BITS  = 16;
  localparam int TIME_BITS = 32;
  localparam int SLOT_BITS = $clog2(SLOTS);
  localparam int CNT_BITS  = SLOT_BITS + 1;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_DELETE,
    OP_RUN,
    OP_SETBACK
  } op_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef logic [KEY_BITS-1:0]  key_t;
  typedef logic [TIME_BITS-1:0] tval_t;
  typedef logic [SLOT_BITS-1:0] slot_idx_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] event_key;
    logic [31:0] period;
    logic [31:0] now;
    logic [31:0] setback_amount;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        fired;
    logic [3:0]  slot_index;
    logic [15:0] fired_key;
    logic        last;
  } rsp_t;

  typedef struct packed {
    key_t  key;
    tval_t due;
    tval_t period;
  } slot_t;

  function automatic key_t key_from_field(logic [15:0] f);
    logic [KEY_BITS+15:0] w;
    w = {{KEY_BITS{1'b0}}, f};
    return w[KEY_BITS-1:0];
  endfunction

  function automatic logic [15:0] key_to_field(key_t k);
    logic [KEY_BITS+15:0] w;
    w = {16'b0, k};
    return w[15:0];
  endfunction

  function automatic tval_t tval_from_field(logic [31:0] f);
    logic [TIME_BITS+31:0] w;
    w = {{TIME_BITS{1'b0}}, f};
    return w[TIME_BITS-1:0];
  endfunction

  function automatic logic [3:0] slot_to_index(slot_idx_t s);
    logic [SLOT_BITS+3:0] w;
    w = {4'b0, s};
    return w[3:0];
  endfunction

  function automatic tval_t sat_add(tval_t a, tval_t b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
  endfunction

endpackage

// ----- hdl/pett_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
// Has no dependencies.
module pett_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/periodic_event_timer_table_core.sv -----
// Each command is taken only while the core is idle; then every slot is read once and
// written back where the command hits, one slot a cycle through the slot RAM while no
// firing waits on a stalled output, and no new command is taken until the final result
// is in the output register; it follows the scan, while fired results of a run come
// out during the scan. Synchronous reset clears all active bits and the control state;
// the slot RAM holds no reset value, and its data is used only for active slots.
module periodic_event_timer_table_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_stall,
  input  pett_pkg::cmd_t  cmd,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output pett_pkg::rsp_t  rsp
);

  pett_pkg::state_t                 state;
  pett_pkg::state_t                 state_next;
  pett_pkg::cmd_t                   req;
  logic [pett_pkg::SLOTS-1:0]       active;
  logic [pett_pkg::CNT_BITS-1:0]    rd_idx;
  logic                             proc_valid;
  pett_pkg::slot_idx_t              proc_idx;
  logic                             found;
  pett_pkg::slot_idx_t              found_idx;
  logic [15:0]                      pend_key;

  pett_pkg::slot_t                  slot_q;
  pett_pkg::slot_t                  wr_data;
  pett_pkg::rsp_t                   rsp_next;
  pett_pkg::key_t                   req_key;
  pett_pkg::tval_t                  req_period;
  pett_pkg::tval_t                  req_now;
  pett_pkg::tval_t                  req_amount;
  logic                             accept;
  logic                             scanning;
  logic                             out_free;
  logic                             hit;
  logic                             hold;
  logic                             rd_more;
  logic                             scan_done;
  logic                             rd_en;
  logic                             wr_en;
  logic                             push_fire;
  logic                             rsp_load;

  assign cmd_stall  = rst || (state != pett_pkg::S_IDLE);
  assign accept     = cmd_valid && !cmd_stall;
  assign scanning   = (state == pett_pkg::S_SCAN);
  assign out_free   = !rsp_valid || !rsp_stall;
  assign req_key    = pett_pkg::key_from_field(req.event_key);
  assign req_period = pett_pkg::tval_from_field(req.period);
  assign req_now    = pett_pkg::tval_from_field(req.now);
  assign req_amount = pett_pkg::tval_from_field(req.setback_amount);
  assign rd_more    = (rd_idx != pett_pkg::CNT_BITS'(pett_pkg::SLOTS));
  assign scan_done  = !proc_valid && !rd_more;

  pett_ram #(
    .WIDTH ($bits(pett_pkg::slot_t)),
    .DEPTH (pett_pkg::SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (proc_idx),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_idx[pett_pkg::SLOT_BITS-1:0]),
    .rd_data (slot_q)
  );

  always_comb begin
    case (req.op)
      pett_pkg::OP_ADD: begin
        hit = proc_valid && !active[proc_idx] && !found;
      end
      pett_pkg::OP_DELETE: begin
        hit = proc_valid && active[proc_idx] && (slot_q.key == req_key) && !found;
      end
      pett_pkg::OP_RUN: begin
        hit = proc_valid && active[proc_idx] && (slot_q.due <= req_now);
      end
      pett_pkg::OP_SETBACK: begin
        hit = proc_valid && active[proc_idx];
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (req.op)
      pett_pkg::OP_ADD: begin
        wr_data = '{key: req_key, due: pett_pkg::sat_add(req_now, req_period),
                    period: req_period};
      end
      pett_pkg::OP_RUN: begin
        wr_data = '{key: slot_q.key, due: pett_pkg::sat_add(req_now, slot_q.period),
                    period: slot_q.period};
      end
      pett_pkg::OP_SETBACK: begin
        wr_data = '{key: slot_q.key,
                    due: (slot_q.due > req_amount) ? (slot_q.due - req_amount) : '0,
                    period: slot_q.period};
      end
      default: begin
        wr_data = '0;
      end
    endcase
  end

  // A second firing of a run needs the output register for the one before it.
  assign hold      = scanning && hit && (req.op == pett_pkg::OP_RUN) && found && !out_free;
  assign rd_en     = scanning && !hold && rd_more;
  assign wr_en     = scanning && hit && !hold;
  assign push_fire = wr_en && (req.op == pett_pkg::OP_RUN) && found;
  assign rsp_load  = push_fire || ((state == pett_pkg::S_FINISH) && out_free);

  always_comb begin
    state_next = state;
    case (state)
      pett_pkg::S_IDLE: begin
        if (accept) begin
          state_next = pett_pkg::S_SCAN;
        end
      end
      pett_pkg::S_SCAN: begin
        if (scan_done) begin
          state_next = pett_pkg::S_FINISH;
        end
      end
      pett_pkg::S_FINISH: begin
        if (out_free) begin
          state_next = pett_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pett_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_next = '{status: pett_pkg::ST_OK, fired: 1'b0, slot_index: 4'd0,
                 fired_key: 16'd0, last: 1'b1};
    if (push_fire) begin
      rsp_next = '{status: pett_pkg::ST_OK, fired: 1'b1,
                   slot_index: pett_pkg::slot_to_index(found_idx),
                   fired_key: pend_key, last: 1'b0};
    end else begin
      case (req.op)
        pett_pkg::OP_ADD: begin
          rsp_next.status     = found ? pett_pkg::ST_OK : pett_pkg::ST_FULL;
          rsp_next.slot_index = found ? pett_pkg::slot_to_index(found_idx) : 4'd0;
          rsp_next.fired_key  = pett_pkg::key_to_field(req_key);
        end
        pett_pkg::OP_DELETE: begin
          rsp_next.status     = found ? pett_pkg::ST_OK : pett_pkg::ST_NOT_FOUND;
          rsp_next.slot_index = found ? pett_pkg::slot_to_index(found_idx) : 4'd0;
          rsp_next.fired_key  = pett_pkg::key_to_field(req_key);
        end
        pett_pkg::OP_RUN: begin
          if (found) begin
            rsp_next.fired      = 1'b1;
            rsp_next.slot_index = pett_pkg::slot_to_index(found_idx);
            rsp_next.fired_key  = pend_key;
          end
        end
        default: begin
          rsp_next.status = pett_pkg::ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pett_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx     <= '0;
      proc_valid <= 1'b0;
      found      <= 1'b0;
      active     <= '0;
    end else if (accept) begin
      rd_idx     <= '0;
      proc_valid <= 1'b0;
      found      <= 1'b0;
    end else if (scanning && !hold) begin
      proc_valid <= rd_en;
      if (rd_en) begin
        rd_idx <= rd_idx + pett_pkg::CNT_BITS'(1);
      end
      if (wr_en) begin
        found <= 1'b1;
        if (req.op == pett_pkg::OP_ADD) begin
          active[proc_idx] <= 1'b1;
        end else if (req.op == pett_pkg::OP_DELETE) begin
          active[proc_idx] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scanning && !hold) begin
      proc_idx <= rd_idx[pett_pkg::SLOT_BITS-1:0];
      if (wr_en) begin
        found_idx <= proc_idx;
        pend_key  <= pett_pkg::key_to_field(slot_q.key);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ----- hdl/pett_checker.sv -----
// Port-level checker for the periodic timer table core, bound into every instance of the core.
// Depends on pett_pkg and the assertion macros in periodic_event_timer_table_core_assert.svh.
`include "periodic_event_timer_table_core_assert.svh"

module pett_checker (
  input logic           clk,
  input logic           rst,
  input logic           cmd_valid,
  input logic           cmd_stall,
  input pett_pkg::cmd_t cmd,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input pett_pkg::rsp_t rsp
);

  // A stalled result must stay in place until its transfer.
  `PETT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

  // The core works on one command at a time.
  `PETT_ASSERT_NEXT(a_busy_after_cmd, cmd_valid && !cmd_stall, cmd_stall)

  // Error results are always the single, final result of a command.
  `PETT_ASSERT_NOW(a_error_is_last,
    !(rsp_valid && (rsp.status != pett_pkg::ST_OK) && (!rsp.last || rsp.fired)))

  // Nothing is offered in the cycle right after reset.
  `PETT_ASSERT_NOW(a_quiet_after_reset, !($past(rst) && rsp_valid))

endmodule

bind periodic_event_timer_table_core pett_checker u_pett_checker (.*);

// ----- tb/tb_top.sv -----
// Self-checking bench for periodic_event_timer_table_core: a directed table, then random
// adds, deletes, runs and set-backs, each checked against a slot-table predictor.
// Depends on pett_pkg and the core; stall and idle pressure vary across three phases.
module tb_top;
  import pett_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_ITEMS = 50;
  localparam int DRAIN_CYCLES = 2 * (SLOTS + 3);

  typedef struct {
    op_t         op;
    logic [15:0] key;
    logic [31:0] period;
    logic [31:0] now;
    logic [31:0] amount;
    int          reps;
    bit          typed;
    rsp_t        want;
  } plan_row_t;

  logic clk;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  logic        tbl_active [SLOTS];
  logic [15:0] tbl_key [SLOTS];
  logic [31:0] tbl_due [SLOTS];
  logic [31:0] tbl_period [SLOTS];

  rsp_t        table_out [$];
  rsp_t        awaited_replies [$];
  rsp_t        want_r;
  logic [15:0] key_pool [8];
  logic [31:0] wall = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;
  int err_count = 0;
  int op_count [4] = '{0, 0, 0, 0};
  int n_replies = 0;
  int n_fired = 0;
  int n_full = 0;
  int n_miss = 0;
  int cur_burst = 0;
  int max_burst = 0;

  periodic_event_timer_table_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic rsp_t make_reply(input logic [1:0] st, input logic f,
                                      input logic [3:0] idx, input logic [15:0] k,
                                      input logic l);
    rsp_t r;
    r = '{st, f, idx, k, l};
    return r;
  endfunction

  function automatic logic [31:0] due_sum(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic void advance_table(input cmd_t c);
    int  n_due;
    int  n_sent;
    bit  done;
    table_out.delete();
    done = 1'b0;
    n_due = 0;
    n_sent = 0;
    case (c.op)
      OP_ADD: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!done && !tbl_active[i]) begin
            tbl_active[i] = 1'b1;
            tbl_key[i] = c.event_key;
            tbl_period[i] = c.period;
            tbl_due[i] = due_sum(c.now, c.period);
            table_out.push_back(make_reply(ST_OK, 1'b0, 4'(i), c.event_key, 1'b1));
            done = 1'b1;
          end
        end
        if (!done) table_out.push_back(make_reply(ST_FULL, 1'b0, 4'd0, c.event_key, 1'b1));
      end
      OP_DELETE: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!done && tbl_active[i] && tbl_key[i] == c.event_key) begin
            tbl_active[i] = 1'b0;
            tbl_key[i] = '0;
            tbl_due[i] = '0;
            tbl_period[i] = '0;
            table_out.push_back(make_reply(ST_OK, 1'b0, 4'(i), c.event_key, 1'b1));
            done = 1'b1;
          end
        end
        if (!done) begin
          table_out.push_back(make_reply(ST_NOT_FOUND, 1'b0, 4'd0, c.event_key, 1'b1));
        end
      end
      OP_RUN: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_active[i] && tbl_due[i] <= c.now) n_due++;
        end
        if (n_due == 0) table_out.push_back(make_reply(ST_OK, 1'b0, 4'd0, 16'h0, 1'b1));
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_active[i] && tbl_due[i] <= c.now) begin
            n_sent++;
            tbl_due[i] = due_sum(c.now, tbl_period[i]);
            table_out.push_back(make_reply(ST_OK, 1'b1, 4'(i), tbl_key[i], n_sent == n_due));
          end
        end
      end
      default: begin
        for (int i = 0; i < SLOTS; i++) begin
          tbl_due[i] = (tbl_due[i] > c.setback_amount) ? tbl_due[i] - c.setback_amount : '0;
        end
        table_out.push_back(make_reply(ST_OK, 1'b0, 4'd0, 16'h0, 1'b1));
      end
    endcase
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int   nact;
    int   pick;
    int   sel;
    c.event_key = 16'($urandom);
    c.period = $urandom;
    c.now = $urandom;
    c.setback_amount = $urandom;
    nact = 0;
    for (int i = 0; i < SLOTS; i++) nact += tbl_active[i];
    sel = $urandom_range(0, 99);
    if (sel < ((nact < 10) ? 45 : 20)) begin
      c.op = OP_ADD;
      if ($urandom_range(0, 99) < 70) c.event_key = key_pool[$urandom_range(0, 7)];
      sel = $urandom_range(0, 99);
      if (sel < 75) c.period = $urandom_range(0, 40);
      else if (sel >= 90) c.period = 32'hFFFF_FFFF - $urandom_range(0, 3);
      if ($urandom_range(0, 99) < 90) c.now = wall;
    end else if (sel < 65) begin
      c.op = OP_DELETE;
      if (nact > 0 && $urandom_range(0, 99) < 80) begin
        pick = $urandom_range(0, nact - 1);
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_active[i]) begin
            if (pick == 0) c.event_key = tbl_key[i];
            pick--;
          end
        end
      end
    end else if (sel < 92) begin
      c.op = OP_RUN;
      wall = wall + $urandom_range(0, 12);
      if ($urandom_range(0, 99) < 92) c.now = wall;
    end else begin
      c.op = OP_SETBACK;
      if ($urandom_range(0, 99) < 80) c.setback_amount = $urandom_range(0, 30);
    end
    return c;
  endfunction

  task automatic send_cmd(input cmd_t c, input bit typed, input rsp_t want);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (cmd_stall);
    op_count[int'(c.op)]++;
    advance_table(c);
    if (typed) awaited_replies.push_back(want);
    else foreach (table_out[i]) awaited_replies.push_back(table_out[i]);
  endtask

  task automatic drain_replies();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
  endtask

  always @(negedge clk) begin
    rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      n_replies++;
      if (awaited_replies.size() == 0) begin
        $error("unexpected result: %p", rsp);
        err_count++;
      end else begin
        want_r = awaited_replies.pop_front();
        if (rsp.status !== want_r.status) begin
          $error("status: expected %0d, got %0d", want_r.status, rsp.status);
          err_count++;
        end
        if (rsp.fired !== want_r.fired) begin
          $error("fired: expected %0d, got %0d", want_r.fired, rsp.fired);
          err_count++;
        end
        if (rsp.slot_index !== want_r.slot_index) begin
          $error("slot_index: expected %0d, got %0d", want_r.slot_index, rsp.slot_index);
          err_count++;
        end
        if (rsp.fired_key !== want_r.fired_key) begin
          $error("fired_key: expected %h, got %h", want_r.fired_key, rsp.fired_key);
          err_count++;
        end
        if (rsp.last !== want_r.last) begin
          $error("last: expected %0d, got %0d", want_r.last, rsp.last);
          err_count++;
        end
      end
      if (rsp.status == ST_FULL) n_full++;
      if (rsp.status == ST_NOT_FOUND) n_miss++;
      if (rsp.fired) begin
        n_fired++;
        cur_burst++;
      end
      if (rsp.last) begin
        if (cur_burst > max_burst) max_burst = cur_burst;
        cur_burst = 0;
      end
    end
  end

  initial begin : stimulus
    plan_row_t plan [18];
    cmd_t      c;
    plan = '{
      '{OP_RUN,     16'h0000, 32'h0,         32'h0,         32'h0,         1, 1'b1,
        make_reply(ST_OK, 1'b0, 4'd0, 16'h0000, 1'b1)},
      '{OP_DELETE,  16'hFFFF, 32'h0,         32'h0,         32'h0,         1, 1'b1,
        make_reply(ST_NOT_FOUND, 1'b0, 4'd0, 16'hFFFF, 1'b1)},
      '{OP_SETBACK, 16'h0000, 32'h0,         32'h0,         32'hFFFF_FFFF, 1, 1'b1,
        make_reply(ST_OK, 1'b0, 4'd0, 16'h0000, 1'b1)},
      '{OP_ADD,     16'h0000, 32'h0,         32'h0,         32'h0,         1, 1'b1,
        make_reply(ST_OK, 1'b0, 4'd0, 16'h0000, 1'b1)},
      '{OP_ADD,     16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0,         1, 1'b1,
        make_reply(ST_OK, 1'b0, 4'd1, 16'hFFFF, 1'b1)},
      '{OP_ADD,     16'h1234, 32'd5,         32'd100,       32'h0,         1, 1'b0, '0},
      '{OP_RUN,     16'h0000, 32'h0,         32'd104,       32'h0,         1, 1'b0, '0},
      '{OP_RUN,     16'h0000, 32'h0,         32'hFFFF_FFFF, 32'h0,         1, 1'b0, '0},
      '{OP_ADD,     16'h0100, 32'd7,         32'd50,        32'h0,        13, 1'b0, '0},
      '{OP_ADD,     16'hAAAA, 32'd9,         32'd9,         32'h0,         1, 1'b1,
        make_reply(ST_FULL, 1'b0, 4'd0, 16'hAAAA, 1'b1)},
      '{OP_SETBACK, 16'h0000, 32'h0,         32'h0,         32'hFFFF_FFFF, 1, 1'b1,
        make_reply(ST_OK, 1'b0, 4'd0, 16'h0000, 1'b1)},
      '{OP_RUN,     16'h0000, 32'h0,         32'h0,         32'h0,         1, 1'b0, '0},
      '{OP_DELETE,  16'h0000, 32'h0,         32'h0,         32'h0,         1, 1'b0, '0},
      '{OP_ADD,     16'h0101, 32'd3,         32'h0,         32'h0,         1, 1'b0, '0},
      '{OP_DELETE,  16'h0101, 32'h0,         32'h0,         32'h0,         1, 1'b0, '0},
      '{OP_ADD,     16'h5A5A, 32'h8000_0000, 32'h8000_0000, 32'h0,         1, 1'b0, '0},
      '{OP_SETBACK, 16'h0000, 32'h0,         32'h0,         32'h5555_AAAA, 1, 1'b1,
        make_reply(ST_OK, 1'b0, 4'd0, 16'h0000, 1'b1)},
      '{OP_RUN,     16'h0000, 32'h0,         32'h7FFF_FFFF, 32'h0,         1, 1'b0, '0}
    };
    for (int i = 0; i < SLOTS; i++) begin
      tbl_active[i] = 1'b0;
      tbl_key[i] = '0;
      tbl_due[i] = '0;
      tbl_period[i] = '0;
    end
    foreach (key_pool[i]) key_pool[i] = 16'($urandom);
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    foreach (plan[r]) begin
      for (int k = 0; k < plan[r].reps; k++) begin
        c.op = plan[r].op;
        c.event_key = plan[r].key + 16'(k);
        c.period = plan[r].period;
        c.now = plan[r].now;
        c.setback_amount = plan[r].amount;
        send_cmd(c, plan[r].typed, plan[r].want);
      end
    end
    drain_replies();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 47 : 0;
      recv_stall_pct = (phase == 0) ? 47 : (phase == 1) ? 31 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) send_cmd(random_cmd(), 1'b0, '0);
      drain_replies();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d commands: %0d adds, %0d deletes, %0d runs, %0d set-backs.",
             op_count[0] + op_count[1] + op_count[2] + op_count[3],
             op_count[0], op_count[1], op_count[2], op_count[3]);
    $display("Saw %0d results: %0d firings (longest burst %0d), %0d full, %0d key misses.",
             n_replies, n_fired, max_burst, n_full, n_miss);
    if (err_count == 0 && awaited_replies.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
